/* design/cwtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwtf_pkg
// Shared types for the text filter and chunker: controller commands and
// datapath status.
// ----------------------------------------------------------------------------
package cwtf_pkg;

  localparam int CHAR_W = 8;

  typedef struct packed {
    logic latch;       // take the input request
    logic emit_split;  // start a chunk up to the split point
    logic emit_final;  // start the closing chunk of the message
    logic append;      // write the held character at the tail
    logic load_char;   // move one window character into the output register
    logic load_empty;  // present the empty-message result
  } cmd_t;

  typedef struct packed {
    logic kept;        // held character is kept and under the cap
    logic last;        // held byte closes the message
    logic full;        // window holds CHUNK_MAX characters
    logic win_empty;   // window holds nothing
    logic emit_last;   // one character left in the chunk being sent
    logic emit_final;  // chunk being sent closes the message
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

/* design/cwtf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwtf_ctrl
// Controller: sequences intake, split emission, append, closing flush and the empty-message result.
// ----------------------------------------------------------------------------
module cwtf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cwtf_pkg::sts_t sts,
  output cwtf_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_EMPTY  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.kept && sts.full) begin
          cmd.emit_split = 1'b1;
          state_nxt      = S_LOAD;
        end else if (sts.kept) begin
          state_nxt = S_APPEND;
        end else if (sts.last) begin
          if (sts.win_empty) begin
            state_nxt = S_EMPTY;
          end else begin
            cmd.emit_final = 1'b1;
            state_nxt      = S_LOAD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = sts.last ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        cmd.emit_final = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_char = 1'b1;
          if (sts.emit_last) begin
            state_nxt = sts.emit_final ? S_IDLE : S_APPEND;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/cwtf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwtf_dp
// Datapath: character cleaning, ring window memory, fill and split tracking,
// output register.
// ----------------------------------------------------------------------------
module cwtf_dp #(
  parameter int CHUNK_MAX   = 30,
  parameter int MESSAGE_CAP = 127
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cwtf_pkg::CHAR_W-1:0]   in_char,
  input  logic                          in_last,
  input  cwtf_pkg::cmd_t                cmd,
  output cwtf_pkg::sts_t                sts,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [cwtf_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_chunk_end,
  output logic                          out_msg_end,
  output logic                          out_empty
);

  localparam int IW = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
  localparam int FW = $clog2(CHUNK_MAX + 1);
  localparam int KW = $clog2(MESSAGE_CAP + 1);
  localparam int CW = cwtf_pkg::CHAR_W;

  localparam logic [CW-1:0] CH_SPACE = 8'h20;
  localparam logic [CW-1:0] CH_COMMA = 8'h2c;
  localparam logic [CW-1:0] CH_DOT   = 8'h2e;
  localparam logic [CW-1:0] CH_SLASH = 8'h2f;
  localparam logic [CW-1:0] CH_QUERY = 8'h3f;
  localparam logic [CW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CW-1:0] CH_NINE  = 8'h39;
  localparam logic [CW-1:0] CH_UA    = 8'h41;
  localparam logic [CW-1:0] CH_UZ    = 8'h5a;
  localparam logic [CW-1:0] CH_LA    = 8'h61;
  localparam logic [CW-1:0] CH_LZ    = 8'h7a;
  localparam logic [CW-1:0] CASE_OFS = 8'h20;

  function automatic logic [CW-1:0] to_upper(input logic [CW-1:0] c);
    if (c >= CH_LA && c <= CH_LZ) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

  function automatic logic is_kept(input logic [CW-1:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_ZERO && c <= CH_NINE) ||
           c == CH_SPACE || c == CH_SLASH || c == CH_QUERY ||
           c == CH_COMMA || c == CH_DOT;
  endfunction

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    if (p == IW'(CHUNK_MAX - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  logic [CW-1:0] win_mem [CHUNK_MAX];
  logic [CW-1:0] rd_data_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  logic [CW-1:0] char_r;
  logic          kept_r,  kept_nxt;
  logic          last_r,  last_nxt;
  logic [IW-1:0] head_r,  head_nxt;
  logic [IW-1:0] tail_r,  tail_nxt;
  logic [FW-1:0] fill_r,  fill_nxt;
  logic [IW-1:0] sp_r,    sp_nxt;
  logic [KW-1:0] kcnt_r,  kcnt_nxt;
  logic [FW-1:0] rem_r,   rem_nxt;
  logic          fin_r,   fin_nxt;
  logic          ov_r,    ov_nxt;
  logic [CW-1:0] oc_r;
  logic          oce_r, ome_r, oem_r;
  logic [CW-1:0] in_up;
  logic          out_free;

  assign in_up    = to_upper(in_char);
  assign out_free = !ov_r || out_tready;

  always_comb begin
    kept_nxt = kept_r;
    last_nxt = last_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    sp_nxt   = sp_r;
    kcnt_nxt = kcnt_r;
    rem_nxt  = rem_r;
    fin_nxt  = fin_r;
    ov_nxt   = ov_r && !out_tready;
    rd_en    = 1'b0;
    rd_addr  = head_r;
    if (cmd.latch) begin
      kept_nxt = is_kept(in_up) && (kcnt_r < KW'(MESSAGE_CAP));
      last_nxt = in_last;
    end
    if (cmd.emit_split) begin
      rem_nxt = (sp_r != '0) ? FW'(sp_r) : FW'(CHUNK_MAX);
      fin_nxt = 1'b0;
      rd_en   = 1'b1;
    end
    if (cmd.emit_final) begin
      rem_nxt = fill_r;
      fin_nxt = 1'b1;
      rd_en   = 1'b1;
    end
    if (cmd.append) begin
      tail_nxt = wrap_inc(tail_r);
      fill_nxt = fill_r + 1'b1;
      kcnt_nxt = kcnt_r + 1'b1;
      if (char_r == CH_SPACE && fill_r != '0) begin
        sp_nxt = fill_r[IW-1:0];
      end
    end
    if (cmd.load_char) begin
      ov_nxt   = 1'b1;
      head_nxt = wrap_inc(head_r);
      fill_nxt = fill_r - 1'b1;
      rem_nxt  = rem_r - 1'b1;
      if (rem_r != FW'(1)) begin
        rd_en   = 1'b1;
        rd_addr = wrap_inc(head_r);
      end else begin
        sp_nxt = '0;
        if (fin_r) begin
          kcnt_nxt = '0;
        end
      end
    end
    if (cmd.load_empty) begin
      ov_nxt   = 1'b1;
      kcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      win_mem[tail_r] <= char_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_r <= in_up;
    end
    if (cmd.load_char) begin
      oc_r  <= rd_data_r;
      oce_r <= (rem_r == FW'(1));
      ome_r <= (rem_r == FW'(1)) && fin_r;
      oem_r <= 1'b0;
    end else if (cmd.load_empty) begin
      oc_r  <= '0;
      oce_r <= 1'b0;
      ome_r <= 1'b1;
      oem_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= 1'b0;
      last_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      sp_r   <= '0;
      kcnt_r <= '0;
      rem_r  <= '0;
      fin_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      kept_r <= kept_nxt;
      last_r <= last_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      sp_r   <= sp_nxt;
      kcnt_r <= kcnt_nxt;
      rem_r  <= rem_nxt;
      fin_r  <= fin_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_comb begin
    sts.kept       = kept_r;
    sts.last       = last_r;
    sts.full       = (fill_r == FW'(CHUNK_MAX));
    sts.win_empty  = (fill_r == '0);
    sts.emit_last  = (rem_r == FW'(1));
    sts.emit_final = fin_r;
    sts.out_free   = out_free;
  end

  assign out_valid     = ov_r;
  assign out_char      = oc_r;
  assign out_chunk_end = oce_r;
  assign out_msg_end   = ome_r;
  assign out_empty     = oem_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(CHUNK_MAX))
    else $error("window fill beyond capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_char || cmd.load_empty) |-> out_free)
    else $error("output register overwritten while stalled");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.append && rd_en))
    else $error("window write and read in one cycle");

  a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oem_r) |-> (ome_r && !oce_r && oc_r == '0))
    else $error("empty-message result malformed");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_char && fin_r && rem_r == FW'(1)) |=> (fill_r == '0 && kcnt_r == '0))
    else $error("message end left state behind");
`endif

endmodule

/* design/cw_text_filter_chunker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cw_text_filter_chunker_core
// Cleans message bytes and sends them out in word-aligned chunks.
//
// Channel  Dir  tdata          tlast            tuser
// in_      in   char_code      last_of_message  -
// out_     out  out_char       chunk_end        {empty_message, message_end}
//
// A byte is taken, then decided, then written to the window when kept. The
// first character of a chunk is presented after the split or flush decision
// through the window memory read, then the output register load; then one
// character a cycle follows while out_tready stays high.
// Synchronous active-low reset; the window needs no clearing pass.
// Bytes are not taken while a chunk drains; a stalled output holds intake
// until the output register frees.
// ----------------------------------------------------------------------------
module cw_text_filter_chunker_core #(
  parameter int CHUNK_MAX   = 30,
  parameter int MESSAGE_CAP = 127
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] message_end, [1] empty_message
);

  cwtf_pkg::cmd_t cmd;
  cwtf_pkg::sts_t sts;

  cwtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cwtf_dp #(
    .CHUNK_MAX   (CHUNK_MAX),
    .MESSAGE_CAP (MESSAGE_CAP)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_char       (in_tdata),
    .in_last       (in_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_char      (out_tdata),
    .out_chunk_end (out_tlast),
    .out_msg_end   (out_tuser[0]),
    .out_empty     (out_tuser[1])
  );

endmodule

/* tb/tb_cw_text_filter_chunker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cw_text_filter_chunker_checker
// Watches both streams of the chunker. Each accepted input request is run
// through a local model of the filter and the chunk window. The model queues
// the characters it expects. Every accepted output request is compared
// against the oldest queued character.
// ----------------------------------------------------------------------------
module tb_cw_text_filter_chunker_checker #(
  parameter int CHUNK_MAX   = 30,
  parameter int MESSAGE_CAP = 127
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  input  logic [1:0] out_tuser,
  output int         mismatches,
  output int         chars_due_n,
  output int         chars_seen,
  output int         chunks_seen
);

  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_QUERY = "?";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_STOP  = ".";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_Z     = "Z";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic       chunk_end;
    logic       msg_end;
    logic       empty;
  } out_char_t;

  out_char_t  chars_due [$];
  logic [7:0] win [CHUNK_MAX];
  int         win_fill;
  int         kept_cnt;
  int         errs;
  int         seen;
  int         chunks;

  initial begin
    win_fill = 0;
    kept_cnt = 0;
    errs     = 0;
    seen     = 0;
    chunks   = 0;
  end

  function automatic logic kept_char(input logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) || c == CH_SPACE ||
           c == CH_SLASH || c == CH_QUERY || c == CH_COMMA || c == CH_STOP;
  endfunction

  // send the first len window characters as one chunk, shift the rest down
  task automatic send_front(input int len, input logic closing);
    out_char_t oc;
    int        i;
    for (i = 0; i < len; i++) begin
      oc.ch        = win[i];
      oc.chunk_end = (i == len - 1);
      oc.msg_end   = (i == len - 1) && closing;
      oc.empty     = 1'b0;
      chars_due.push_back(oc);
    end
    for (i = 0; i < win_fill - len; i++)
      win[i] = win[i + len];
    win_fill = win_fill - len;
  endtask

  task automatic take_byte(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    int         split;
    int         i;
    out_char_t  oc;
    c = raw;
    if (c >= CH_LA && c <= CH_LZ)
      c = c - CASE_GAP;
    if (kept_char(c) && kept_cnt < MESSAGE_CAP) begin
      kept_cnt++;
      if (win_fill >= CHUNK_MAX) begin
        split = 0;
        // a space at the front never counts as a split point
        for (i = 1; i < CHUNK_MAX; i++)
          if (win[i] == CH_SPACE)
            split = i;
        if (split == 0)
          split = CHUNK_MAX;
        send_front(split, 1'b0);
      end
      win[win_fill] = c;
      win_fill++;
    end
    if (last) begin
      if (win_fill == 0) begin
        oc.ch        = 8'h00;
        oc.chunk_end = 1'b0;
        oc.msg_end   = 1'b1;
        oc.empty     = 1'b1;
        chars_due.push_back(oc);
      end else begin
        send_front(win_fill, 1'b1);
      end
      win_fill = 0;
      kept_cnt = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    out_char_t got;
    out_char_t want;
    if (!rst_n) begin
      chars_due.delete();
      win_fill = 0;
      kept_cnt = 0;
    end else begin
      // output first: a request leaving now cannot stem from a byte taken now
      if (out_tvalid && out_tready) begin
        got.ch        = out_tdata;
        got.chunk_end = out_tlast;
        got.msg_end   = out_tuser[0];
        got.empty     = out_tuser[1];
        seen++;
        if (out_tlast)
          chunks++;
        if (chars_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected output request char=%02h last=%b user=%b",
                     $realtime, out_tdata, out_tlast, out_tuser);
        end else begin
          want = chars_due.pop_front();
          if (got.ch !== want.ch || got.chunk_end !== want.chunk_end ||
              got.msg_end !== want.msg_end || got.empty !== want.empty) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch char exp %02h got %02h, chunk_end exp %b got %b, %s%b %s%b",
                       $realtime, want.ch, got.ch, want.chunk_end, got.chunk_end,
                       "msg_end/empty exp ", {want.msg_end, want.empty},
                       "got ", {got.msg_end, got.empty});
          end
        end
      end
      if (in_tvalid && in_tready)
        take_byte(in_tdata, in_tlast);
    end
    mismatches  <= errs;
    chars_due_n <= chars_due.size();
    chars_seen  <= seen;
    chunks_seen <= chunks;
  end

endmodule

/* tb/tb_cw_text_filter_chunker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cw_text_filter_chunker_core
// Drives message bytes into the text chunker and paces the chunk output.
// A short directed set covers the character classes and the empty and
// dropped-last cases. Random messages of words, long unbroken runs,
// space-heavy text, noise and empty messages follow. One message overruns
// the per-message cap while the output is held off. The checker beside the
// block does the predicting and comparing.
// ----------------------------------------------------------------------------
module tb_cw_text_filter_chunker_core;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CAP_BYTES    = 135;
  localparam int RANDOM_BYTES = 24;

  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_QUERY = "?";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_STOP  = ".";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_0     = "0";

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] char_code
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_char
  logic       out_tlast;
  logic [1:0] out_tuser;  // [0] message_end, [1] empty_message

  int         mismatches;
  int         chars_due_n;
  int         chars_seen;
  int         chunks_seen;

  logic [7:0] msg_bytes [$];
  int         msgs_sent  = 0;
  int         bytes_sent = 0;
  int         hold_reqs  = 0;
  int         holds_done = 0;
  int         cycles     = 0;
  bit         tx_steady  = 1'b0;
  bit         rx_steady  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cw_text_filter_chunker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  tb_cw_text_filter_chunker_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .chars_due_n (chars_due_n),
    .chars_seen  (chars_seen),
    .chunks_seen (chunks_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_cw_text_filter_chunker_core: done, errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      return CH_A + 8'($urandom_range(0, 25));
    if (r < 65)
      return CH_LA + 8'($urandom_range(0, 25));
    if (r < 85)
      return CH_0 + 8'($urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0:       return CH_SLASH;
      1:       return CH_QUERY;
      2:       return CH_COMMA;
      default: return CH_STOP;
    endcase
  endfunction

  // bytes the filter throws away
  function automatic logic [7:0] dropped_char();
    case ($urandom_range(0, 6))
      0:       return 8'($urandom_range(8'h00, 8'h1f));
      1:       return 8'($urandom_range(8'h21, 8'h2b));
      2:       return 8'h2d;
      3:       return 8'($urandom_range(8'h3a, 8'h3e));
      4:       return 8'h40;
      5:       return 8'($urandom_range(8'h5b, 8'h60));
      default: return 8'($urandom_range(8'h7b, 8'hff));
    endcase
  endfunction

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      msg_bytes.push_back(s[i]);
  endtask

  task automatic build_text(input int len, input int space_pct, input int drop_pct);
    int k;
    int r;
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < drop_pct)
        msg_bytes.push_back(dropped_char());
      else if (r < drop_pct + space_pct)
        msg_bytes.push_back(CH_SPACE);
      else
        msg_bytes.push_back(word_char());
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
    msgs_sent++;
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = rx_steady ? 0 : pick_gap();
        if (gap == 0) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int  kind;
    int  start_bytes;
    bit  second_hold;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every kept class and the edges of the letter ranges
    add_str("az AZ09/?,.");
    send_message();
    // empty message from a single zero byte
    msg_bytes.push_back(8'h00);
    send_message();
    // only dropped bytes, closing on the top value
    add_str("@[`{");
    msg_bytes.push_back(8'h7f);
    msg_bytes.push_back(8'hff);
    send_message();
    // dropped last byte still closes a non-empty message
    add_str("x");
    msg_bytes.push_back(8'h80);
    send_message();
    add_str(" ");
    send_message();
    add_str("9");
    send_message();

    // overrun the cap with the output held so intake backs up
    start_bytes = bytes_sent;
    tx_steady   = 1'b1;
    hold_reqs  <= hold_reqs + 1;
    build_text(CAP_BYTES, 12, 0);
    send_message();

    second_hold = 1'b0;
    while (bytes_sent < start_bytes + CAP_BYTES + RANDOM_BYTES) begin
      rx_steady <= ($urandom_range(0, 3) == 0);
      if (!second_hold) begin
        second_hold = 1'b1;
        tx_steady   = 1'b1;
        hold_reqs  <= hold_reqs + 1;
      end else begin
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 45)
        build_text($urandom_range(1, 70), 15, 5);
      else if (kind < 60)
        build_text($urandom_range(31, 70), 0, 3);
      else if (kind < 72)
        build_text($urandom_range(25, 65), 45, 0);
      else if (kind < 88)
        repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      else
        repeat ($urandom_range(1, 4)) msg_bytes.push_back(dropped_char());
      if ($urandom_range(0, 4) == 0)
        msg_bytes.push_back(dropped_char());
      send_message();
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (chars_due_n != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d messages (%0d bytes), checked %0d output chars in %0d chunks",
             msgs_sent, bytes_sent, chars_seen, chunks_seen);
    $display("cap overrun and two long output hold-offs included, %0d mismatches",
             mismatches);
    if (mismatches == 0 && chars_due_n == 0)
      $display("tb_cw_text_filter_chunker_core: done, clean");
    else
      $display("tb_cw_text_filter_chunker_core: done, errors");
    $finish;
  end

endmodule
